// ===== rtl/tulb_pkg.sv =====
// Package for the texture unit LRU binder.
// Holds the request/result payload types, opcodes, FSM states and the
// controller/datapath interface structs; no dependencies.
`default_nettype none
package tulb_pkg;

  localparam int UNITS_DEFAULT = 16;
  localparam int UNIT_W        = 6;
  localparam int TEX_W         = 32;
  localparam int STAMP_W       = 64;

  typedef enum logic {
    OP_BIND   = 1'b0,
    OP_UNBIND = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TEX_W-1:0] tex_id;
  } req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              already_bound;
    logic              found;
    logic              evicted;
    logic [TEX_W-1:0]  evicted_tex;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // capture request, restart scan
    logic issue;   // read the unit at the scan pointer
    logic finish;  // resolve, update the table, post the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_issue;  // scan pointer is at the final unit
  } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/tulb_ctrl.sv =====
// Controller FSM for the texture unit LRU binder.
// Sequences request capture, the unit scan and the final update.
// Depends on tulb_pkg.
`default_nettype none
module tulb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  tulb_pkg::ctrl_stat_t stat,
  output tulb_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  tulb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tulb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tulb_pkg::ST_IDLE: begin
        if (start) state_next = tulb_pkg::ST_SCAN;
      end
      tulb_pkg::ST_SCAN: begin
        if (stat.last_issue) state_next = tulb_pkg::ST_LAST;
      end
      tulb_pkg::ST_LAST: state_next = tulb_pkg::ST_DONE;
      tulb_pkg::ST_DONE: state_next = tulb_pkg::ST_IDLE;
      default:           state_next = tulb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      tulb_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tulb_pkg::ST_SCAN: cmd.issue  = 1'b1;
      tulb_pkg::ST_LAST: ;
      tulb_pkg::ST_DONE: cmd.finish = 1'b1;
      default:           ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tulb_datapath.sv =====
// Datapath for the texture unit LRU binder: unit tables, per-unit valid bits,
// use counter, scan accumulators and the result register.
// Depends on tulb_pkg.
`default_nettype none
module tulb_datapath #(
  parameter int UNITS = tulb_pkg::UNITS_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  tulb_pkg::req_t       request,
  input  tulb_pkg::ctrl_cmd_t  cmd,
  output tulb_pkg::ctrl_stat_t stat,
  output tulb_pkg::res_t       result,
  output logic                 done
);

  localparam int IDX_W = $clog2(UNITS);
  localparam int TW    = tulb_pkg::TEX_W;
  localparam int SW    = tulb_pkg::STAMP_W;

  logic [TW-1:0]    tex_mem   [UNITS];
  logic [SW-1:0]    stamp_mem [UNITS];
  logic [UNITS-1:0] valid;
  logic [SW-1:0]    counter;

  tulb_pkg::req_t req;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  logic [TW-1:0]    rd_tex;
  logic [SW-1:0]    rd_stamp;

  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             empty_found;
  logic [IDX_W-1:0] empty_idx;
  logic             min_seen;
  logic [IDX_W-1:0] min_idx;
  logic [SW-1:0]    min_stamp;
  logic [TW-1:0]    min_tex;

  logic             ent_valid;
  logic [SW-1:0]    ent_stamp;
  logic [SW-1:0]    new_stamp;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             clr_en;
  logic             bump;
  tulb_pkg::res_t   res_next;

  assign stat.last_issue = (rd_addr == IDX_W'(UNITS - 1));
  assign ent_valid       = valid[rd_idx];
  assign ent_stamp       = ent_valid ? rd_stamp : '0;
  assign new_stamp       = counter + SW'(1);

  // table memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tex_mem[wr_idx]   <= req.tex_id;
      stamp_mem[wr_idx] <= new_stamp;
    end
    if (cmd.issue) begin
      rd_tex   <= tex_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

  // scan pointer and accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= request;
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
    if (cmd.issue) rd_idx <= rd_addr;

    if (cmd.load) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      min_seen    <= 1'b0;
    end else if (rd_live) begin
      if (ent_valid && rd_tex == req.tex_id && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (!ent_valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= rd_idx;
      end
      // strict compare keeps the lowest index on ties
      if (!min_seen || ent_stamp < min_stamp) begin
        min_seen  <= 1'b1;
        min_idx   <= rd_idx;
        min_stamp <= ent_stamp;
        min_tex   <= ent_valid ? rd_tex : '0;
      end
    end
  end

  // resolve the request once the scan has covered every unit
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = '0;
    clr_en   = 1'b0;
    bump     = 1'b0;
    res_next = '0;
    if (cmd.finish && req.tex_id != '0) begin
      if (req.op == tulb_pkg::OP_UNBIND) begin
        if (hit_found) begin
          clr_en         = 1'b1;
          res_next.unit  = tulb_pkg::UNIT_W'(hit_idx);
          res_next.found = 1'b1;
        end
      end else begin
        bump           = 1'b1;
        wr_en          = 1'b1;
        res_next.found = 1'b1;
        if (hit_found) begin
          wr_idx                 = hit_idx;
          res_next.already_bound = 1'b1;
        end else if (empty_found) begin
          wr_idx = empty_idx;
        end else begin
          wr_idx               = min_idx;
          res_next.evicted     = 1'b1;
          res_next.evicted_tex = min_tex;
        end
        res_next.unit = tulb_pkg::UNIT_W'(wr_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      counter <= '0;
      rd_live <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_live <= cmd.issue;
      done    <= cmd.finish;
      if (bump) counter <= new_stamp;
      if (wr_en) valid[wr_idx] <= 1'b1;
      if (clr_en) valid[hit_idx] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/texture_unit_lru_binder.sv =====
// Texture unit LRU binder: fully associative unit table, LRU by timestamps.
// After the start transfer the units are scanned one per cycle through the
// tables' single read port, then the result is posted with the done strobe.
// One request at a time: a new start is taken only once busy drops, as done rises.
// The receiver cannot stall; done is high for exactly one cycle per result.
// Reset (rst, synchronous): every unit empty and use counter zero; stamps are not reset.
`default_nettype none
module texture_unit_lru_binder #(
  parameter int UNITS = tulb_pkg::UNITS_DEFAULT
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  tulb_pkg::req_t request,
  output logic           done,
  output tulb_pkg::res_t result
);

  tulb_pkg::ctrl_cmd_t  cmd;
  tulb_pkg::ctrl_stat_t stat;

  tulb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tulb_datapath #(
    .UNITS (UNITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule
`default_nettype wire

// ===== rtl/tulb_checker.sv =====
// Port-level checker for the texture unit LRU binder, bound to the top level.
// Depends on tulb_pkg.
`default_nettype none
module tulb_checker (
  input wire            clk,
  input wire            rst,
  input wire            start,
  input wire            busy,
  input wire            done,
  input tulb_pkg::res_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result posted while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_evict_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.evicted) |-> (result.found && !result.already_bound))
    else $error("eviction without a plain bind");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |->
      (result.unit == '0 && !result.evicted && result.evicted_tex == '0))
    else $error("unfound request carries nonzero fields");

endmodule

bind texture_unit_lru_binder tulb_checker u_tulb_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
`default_nettype wire

// ===== tb/texture_unit_lru_binder_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the texture unit LRU binder: predicts each request from
// its own copy of the unit table and compares every strobed result.
// Depends on tulb_pkg for the request/result payload types and opcodes.
module texture_unit_lru_binder_checker
  import tulb_pkg::*;
#(
  parameter int UNITS = UNITS_DEFAULT
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  input  wire  busy,
  input  req_t request,
  input  wire  done,
  input  res_t result,
  output int   mismatch_count,
  output int   pending
);

  logic [TEX_W-1:0]   bound_tex [UNITS];
  logic [STAMP_W-1:0] last_use  [UNITS];
  logic [STAMP_W-1:0] bind_clock;
  res_t               expected_results [$];

  initial begin
    mismatch_count = 0;
    pending        = 0;
  end

  // Apply one request to the shadow table and return the result it must give.
  function automatic res_t predict_binding(req_t rq);
    res_t r;
    int   hit;
    int   hole;
    int   victim;
    r      = '0;
    hit    = -1;
    hole   = -1;
    victim = 0;
    if (rq.tex_id == '0) begin
      return r;
    end
    for (int i = UNITS - 1; i >= 0; i--) begin
      if (bound_tex[i] == rq.tex_id) hit = i;
      if (bound_tex[i] == '0) hole = i;
    end
    if (rq.op == OP_UNBIND) begin
      if (hit >= 0) begin
        bound_tex[hit] = '0;
        last_use[hit]  = '0;
        r.unit  = UNIT_W'(hit);
        r.found = 1'b1;
      end
      return r;
    end
    bind_clock = bind_clock + 1'b1;
    r.found    = 1'b1;
    if (hit >= 0) begin
      last_use[hit]   = bind_clock;
      r.unit          = UNIT_W'(hit);
      r.already_bound = 1'b1;
    end else if (hole >= 0) begin
      bound_tex[hole] = rq.tex_id;
      last_use[hole]  = bind_clock;
      r.unit          = UNIT_W'(hole);
    end else begin
      // strict compare keeps ties on the lowest unit
      for (int i = 1; i < UNITS; i++) begin
        if (last_use[i] < last_use[victim]) victim = i;
      end
      r.unit          = UNIT_W'(victim);
      r.evicted       = 1'b1;
      r.evicted_tex   = bound_tex[victim];
      bound_tex[victim] = rq.tex_id;
      last_use[victim]  = bind_clock;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t exp;
    if (rst) begin
      for (int i = 0; i < UNITS; i++) begin
        bound_tex[i] = '0;
        last_use[i]  = '0;
      end
      bind_clock = '0;
      expected_results.delete();
    end else begin
      // compare first: a result and the next transfer can share an edge
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %0h",
                   $time, result);
          mismatch_count++;
        end else begin
          exp = expected_results.pop_front();
          check_field("unit", 32'(exp.unit), 32'(result.unit));
          check_field("already_bound", 32'(exp.already_bound), 32'(result.already_bound));
          check_field("found", 32'(exp.found), 32'(result.found));
          check_field("evicted", 32'(exp.evicted), 32'(result.evicted));
          check_field("evicted_tex", exp.evicted_tex, result.evicted_tex);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_binding(request));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_texture_unit_lru_binder.sv =====
`timescale 1ns / 1ps
// Top of the texture unit LRU binder testbench: clock, reset, request
// stimulus, watchdog and verdict. Uses tulb_pkg and the result checker.
module tb_texture_unit_lru_binder;
  import tulb_pkg::*;

  localparam int UNITS       = UNITS_DEFAULT;
  localparam int RANDOM_REQS = 450;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  res_t result;
  int   mismatch_count;
  int   pending;
  int   quiet_cycles = 0;

  logic [TEX_W-1:0] id_pool [32];
  int               pool_size;

  always #5 clk = ~clk;

  texture_unit_lru_binder #(.UNITS(UNITS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  texture_unit_lru_binder_checker #(.UNITS(UNITS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // Drive one request from a falling edge; hold it until the transfer.
  task automatic send_request(op_t op, logic [TEX_W-1:0] id, bit allow_idle);
    int gap;
    while (busy) @(negedge clk);
    if (allow_idle && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, UNITS + 6);
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    request.op     <= op;
    request.tex_id <= id;
    // busy is low here, so the transfer takes place at the next rising edge
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic refill_pool();
    pool_size = $urandom_range(6, 28);
    for (int i = 0; i < 32; i++) begin
      id_pool[i] = $urandom();
      if (id_pool[i] == '0) id_pool[i] = 32'h1;
    end
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int   pick;
    bit   idle_ok;
    op_t  op;
    logic [TEX_W-1:0] id;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reserved id, unbind misses, id extremes, hit, fill, eviction, hole reuse
    send_request(OP_BIND, '0, 1'b0);
    send_request(OP_UNBIND, '0, 1'b0);
    send_request(OP_UNBIND, 32'd5, 1'b0);
    send_request(OP_BIND, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_BIND, 32'h1, 1'b0);
    send_request(OP_BIND, 32'hFFFF_FFFF, 1'b0);
    for (int i = 0; i < UNITS - 2; i++) send_request(OP_BIND, 32'd100 + i, 1'b1);
    send_request(OP_BIND, 32'h1, 1'b0);
    send_request(OP_BIND, 32'hAAAA_5555, 1'b0);
    send_request(OP_UNBIND, 32'd105, 1'b0);
    send_request(OP_BIND, 32'h5555_AAAA, 1'b0);
    send_request(OP_UNBIND, 32'd105, 1'b1);
    send_request(OP_BIND, 32'd200, 1'b1);

    refill_pool();
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 90 == 89) refill_pool();
      idle_ok = !(n >= 150 && n < 300);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op = $urandom_range(0, 1) ? OP_UNBIND : OP_BIND;
        id = '0;
      end else if (pick < 8) begin
        op = $urandom_range(0, 1) ? OP_UNBIND : OP_BIND;
        id = $urandom();
      end else begin
        op = (pick < 72) ? OP_BIND : OP_UNBIND;
        id = id_pool[$urandom_range(0, pool_size - 1)];
      end
      send_request(op, id, idle_ok);
    end

    while (pending != 0) @(negedge clk);
    repeat (UNITS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tulb_pkg.sv
rtl/tulb_ctrl.sv
rtl/tulb_datapath.sv
rtl/texture_unit_lru_binder.sv
rtl/tulb_checker.sv
tb/texture_unit_lru_binder_checker.sv
tb/tb_texture_unit_lru_binder.sv
